[rtl/mpc_pkg.sv]
// Package for the max-points-in-unit-circle block: beat types, fixed widths
// and the arctangent table of the angle unit. No dependencies.
`default_nettype none

package mpc_pkg;

  // Widths fixed by the coordinate format of the input beat.
  localparam int COORD_W   = 24;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int D2_W      = 2 * DIFF_W;
  localparam int SQ_W      = 52;
  localparam int ROOT_W    = SQ_W / 2;
  localparam int CIN_W     = ROOT_W + 1;
  localparam int OUT_CNT_W = 10;

  // Angle unit: vectors are scaled up until one component reaches bit NORM_SH.
  localparam int V_W     = 45;
  localparam int NORM_SH = 40;
  localparam int Z_W     = 34;
  localparam int STEPS   = 32;
  localparam int STEP_W  = 5;

  // Arctangent of 2^-i in units of 2^-32 turn.
  localparam logic [31:0] ATAN_TAB [STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic                      last_point;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_CNT_W-1:0] max_covered;
    logic                 overflow;
  } out_beat_t;

  // Commands from the sequencer to the event sorter.
  typedef struct packed {
    logic clr;
    logic push;
    logic go;
  } sw_cmd_t;

endpackage

`default_nettype wire

[rtl/max_points_in_unit_circle.sv]
// Top level of the max-points-in-unit-circle block: point store and sweep
// sequencer. Depends on mpc_pkg, mpc_isqrt, mpc_cordic and mpc_sweep.
//
// Usage: points arrive on in_data, one beat per cycle, accepted when start is
// high and busy is low. Each beat is stored in the point memory; the beat
// with last_point set closes the set and raises busy. The block then
// sweeps around every stored point. A neighbor farther than two units passes
// through selection, difference, d^2 on one shared multiplier and the range
// check. A neighbor within range adds up to two square roots on the shared
// root unit, up to two angles on the shared CORDIC unit (each after its
// normalizing shifts) and, unless the half arc rounds to nothing, two event
// writes. Each center then heap-sorts its arc ends in the event memory and
// scans them.
// When done, out_valid is high for exactly one cycle with out_data, and busy
// falls in the same cycle; the receiver cannot stall the result. Points past
// MAX_POINTS are dropped and reported in out_data.overflow.
// Reset empties the point set and clears the drop flag; the memories hold no
// reset state and are only read where written.
`default_nettype none

module max_points_in_unit_circle #(
  parameter int MAX_POINTS = 512,
  parameter int FRAC_BITS  = 16,
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire mpc_pkg::in_beat_t   in_data,
  output logic                     out_valid,
  output mpc_pkg::out_beat_t       out_data
);

  localparam int PA_W   = $clog2(MAX_POINTS);
  localparam int PC_W   = $clog2(MAX_POINTS + 1);
  localparam int CNT_W  = PC_W + 1;
  localparam int KEY_W  = ANGLE_BITS + 1;
  localparam int CW     = mpc_pkg::COORD_W;
  localparam int DW     = mpc_pkg::DIFF_W;
  localparam int D2W    = mpc_pkg::D2_W;
  localparam int CIW    = mpc_pkg::CIN_W;
  localparam logic [63:0] FOUR_SQ = 64'd1 << (2 * FRAC_BITS + 2);
  localparam logic [63:0] TOL_SQ  = FOUR_SQ / 64'd25000000;
  localparam logic [63:0] LIMIT   = FOUR_SQ + TOL_SQ;

  typedef enum logic [3:0] {
    T_IDLE, T_IRD, T_ILAT, T_JSEL, T_JDIFF, T_MULX, T_MULY, T_ADD,
    T_CHK, T_SQD, T_SQH, T_ANGH, T_ANGA, T_EVS, T_EVE, T_SORT
  } tst_t;

  logic [2*CW-1:0] pmem [MAX_POINTS];
  logic [2*CW-1:0] pt_rd_r;

  tst_t                         st_r, st_nxt;
  logic [PC_W-1:0]              pcnt_r, pcnt_nxt, i_r, i_nxt, j_r, j_nxt;
  logic                         drop_r, drop_nxt;
  logic signed [CW-1:0]         xi_r, xi_nxt, yi_r, yi_nxt, xj, yj;
  logic signed [DW-1:0]         dx_r, dx_nxt, dy_r, dy_nxt, mul_op;
  logic signed [2*DW-1:0]       mul_p;
  logic [D2W-1:0]               d2_r, d2_nxt, sq_r, sq_nxt;
  logic [mpc_pkg::ROOT_W-1:0]   d_r, d_nxt, sq_root;
  logic [ANGLE_BITS-1:0]        half_r, half_nxt, s_r, s_nxt, e_r, e_nxt, cd_ang;
  logic [ANGLE_BITS-1:0]        s_c, e_c;
  logic [CNT_W-1:0]             cnt0_r, cnt0_nxt, best_r, best_nxt, sw_peak, best_cand;
  logic                         sq_go_r, sq_go_nxt, sq_done;
  logic [mpc_pkg::SQ_W-1:0]     sq_rad_r, sq_rad_nxt;
  logic                         cd_go_r, cd_go_nxt, cd_done;
  logic signed [CIW-1:0]        cd_x_r, cd_x_nxt, cd_y_r, cd_y_nxt;
  mpc_pkg::sw_cmd_t             swc_r, swc_nxt;
  logic [KEY_W-1:0]             key_r, key_nxt;
  logic                         sw_done;
  logic                         out_valid_r, out_valid_nxt;
  mpc_pkg::out_beat_t           out_data_r, out_data_nxt;
  logic                         accept, pm_we;
  logic [PA_W-1:0]              pm_raddr;
  logic [31:0]                  best_ext;
  logic [PC_W-1:0]              i_inc;

  assign accept = start && (st_r == T_IDLE);
  assign pm_we  = accept && (pcnt_r < PC_W'(MAX_POINTS));

  // Point memory: written on accepted beats, read by the sweep sequencer.
  always_ff @(posedge clk) begin
    if (pm_we) begin
      pmem[pcnt_r[PA_W-1:0]] <= {in_data.x_coord, in_data.y_coord};
    end
    pt_rd_r <= pmem[pm_raddr];
  end

  // Shared multiplier operand: dx in T_MULX, dy in T_MULY.
  assign mul_op = (st_r == T_MULX) ? dx_r : dy_r;
  assign mul_p  = mul_op * mul_op;

  always_comb begin
    st_nxt        = st_r;
    pcnt_nxt      = pcnt_r;
    drop_nxt      = drop_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    xi_nxt        = xi_r;
    yi_nxt        = yi_r;
    dx_nxt        = dx_r;
    dy_nxt        = dy_r;
    d2_nxt        = d2_r;
    sq_nxt        = sq_r;
    d_nxt         = d_r;
    half_nxt      = half_r;
    s_nxt         = s_r;
    e_nxt         = e_r;
    cnt0_nxt      = cnt0_r;
    best_nxt      = best_r;
    sq_go_nxt     = 1'b0;
    sq_rad_nxt    = sq_rad_r;
    cd_go_nxt     = 1'b0;
    cd_x_nxt      = cd_x_r;
    cd_y_nxt      = cd_y_r;
    swc_nxt       = '0;
    key_nxt       = key_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    pm_raddr      = (st_r == T_IRD) ? i_r[PA_W-1:0] : j_r[PA_W-1:0];
    xj            = pt_rd_r[2*CW-1:CW];
    yj            = pt_rd_r[CW-1:0];
    s_c           = cd_ang - half_r;
    e_c           = cd_ang + half_r;
    best_cand     = (sw_peak > best_r) ? sw_peak : best_r;
    best_ext      = 32'(best_cand);
    i_inc         = i_r + 1'b1;
    case (st_r)
      // Load points; the closing beat starts the sweep.
      T_IDLE: begin
        if (accept) begin
          if (pm_we) begin
            pcnt_nxt = pcnt_r + 1'b1;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_data.last_point) begin
            i_nxt  = '0;
            st_nxt = T_IRD;
          end
        end
      end
      T_IRD: st_nxt = T_ILAT;
      T_ILAT: begin
        xi_nxt      = pt_rd_r[2*CW-1:CW];
        yi_nxt      = pt_rd_r[CW-1:0];
        j_nxt       = '0;
        cnt0_nxt    = CNT_W'(1);
        swc_nxt.clr = 1'b1;
        st_nxt      = T_JSEL;
      end
      // Pick the next neighbor, skipping the center point itself.
      T_JSEL: begin
        if (j_r == pcnt_r) begin
          swc_nxt.go = 1'b1;
          st_nxt     = T_SORT;
        end else if (j_r == i_r) begin
          j_nxt = j_r + 1'b1;
        end else begin
          st_nxt = T_JDIFF;
        end
      end
      T_JDIFF: begin
        dx_nxt = DW'(xj) - DW'(xi_r);
        dy_nxt = DW'(yj) - DW'(yi_r);
        st_nxt = T_MULX;
      end
      T_MULX: begin
        d2_nxt = D2W'(mul_p);
        st_nxt = T_MULY;
      end
      T_MULY: begin
        sq_nxt = D2W'(mul_p);
        st_nxt = T_ADD;
      end
      T_ADD: begin
        d2_nxt = d2_r + sq_r;
        st_nxt = T_CHK;
      end
      // Neighbors farther than the circle diameter give no arc.
      T_CHK: begin
        if (64'(d2_r) > LIMIT) begin
          j_nxt  = j_r + 1'b1;
          st_nxt = T_JSEL;
        end else begin
          sq_go_nxt  = 1'b1;
          sq_rad_nxt = mpc_pkg::SQ_W'(d2_r);
          st_nxt     = T_SQD;
        end
      end
      T_SQD: begin
        if (sq_done) begin
          d_nxt = sq_root;
          if (64'(d2_r) < FOUR_SQ) begin
            sq_go_nxt  = 1'b1;
            sq_rad_nxt = mpc_pkg::SQ_W'(FOUR_SQ - 64'(d2_r));
            st_nxt     = T_SQH;
          end else begin
            cd_go_nxt = 1'b1;
            cd_x_nxt  = signed'({1'b0, sq_root});
            cd_y_nxt  = '0;
            st_nxt    = T_ANGH;
          end
        end
      end
      T_SQH: begin
        if (sq_done) begin
          cd_go_nxt = 1'b1;
          cd_x_nxt  = signed'({1'b0, d_r});
          cd_y_nxt  = signed'({1'b0, sq_root});
          st_nxt    = T_ANGH;
        end
      end
      // Half arc width; an arc that rounds to nothing is left out.
      T_ANGH: begin
        if (cd_done) begin
          half_nxt = cd_ang;
          if (cd_ang == '0) begin
            j_nxt  = j_r + 1'b1;
            st_nxt = T_JSEL;
          end else begin
            cd_go_nxt = 1'b1;
            cd_x_nxt  = CIW'(dx_r);
            cd_y_nxt  = CIW'(dy_r);
            st_nxt    = T_ANGA;
          end
        end
      end
      // Arc ends; an arc across the zero angle counts from the start.
      T_ANGA: begin
        if (cd_done) begin
          s_nxt = s_c;
          e_nxt = e_c;
          if (s_c > e_c) begin
            cnt0_nxt = cnt0_r + 1'b1;
          end
          st_nxt = T_EVS;
        end
      end
      T_EVS: begin
        swc_nxt.push = 1'b1;
        key_nxt      = {s_r, 1'b1};
        st_nxt       = T_EVE;
      end
      T_EVE: begin
        swc_nxt.push = 1'b1;
        key_nxt      = {e_r, 1'b0};
        j_nxt        = j_r + 1'b1;
        st_nxt       = T_JSEL;
      end
      // Sort and scan done: keep the best count, then next center or result.
      T_SORT: begin
        if (sw_done) begin
          if (i_inc == pcnt_r) begin
            out_valid_nxt            = 1'b1;
            out_data_nxt.max_covered = (best_ext > 32'd1023) ?
                                       {mpc_pkg::OUT_CNT_W{1'b1}} :
                                       best_ext[mpc_pkg::OUT_CNT_W-1:0];
            out_data_nxt.overflow    = drop_r;
            pcnt_nxt                 = '0;
            drop_nxt                 = 1'b0;
            best_nxt                 = CNT_W'(1);
            st_nxt                   = T_IDLE;
          end else begin
            best_nxt = best_cand;
            i_nxt    = i_inc;
            st_nxt   = T_IRD;
          end
        end
      end
      default: st_nxt = T_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= T_IDLE;
      pcnt_r      <= '0;
      drop_r      <= 1'b0;
      best_r      <= CNT_W'(1);
      sq_go_r     <= 1'b0;
      cd_go_r     <= 1'b0;
      swc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      pcnt_r      <= pcnt_nxt;
      drop_r      <= drop_nxt;
      best_r      <= best_nxt;
      sq_go_r     <= sq_go_nxt;
      cd_go_r     <= cd_go_nxt;
      swc_r       <= swc_nxt;
      out_valid_r <= out_valid_nxt;
    end
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    xi_r       <= xi_nxt;
    yi_r       <= yi_nxt;
    dx_r       <= dx_nxt;
    dy_r       <= dy_nxt;
    d2_r       <= d2_nxt;
    sq_r       <= sq_nxt;
    d_r        <= d_nxt;
    half_r     <= half_nxt;
    s_r        <= s_nxt;
    e_r        <= e_nxt;
    cnt0_r     <= cnt0_nxt;
    sq_rad_r   <= sq_rad_nxt;
    cd_x_r     <= cd_x_nxt;
    cd_y_r     <= cd_y_nxt;
    key_r      <= key_nxt;
    out_data_r <= out_data_nxt;
  end

  mpc_isqrt u_isqrt (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sq_go_r),
    .rad   (sq_rad_r),
    .done  (sq_done),
    .root  (sq_root)
  );

  mpc_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cd_go_r),
    .x_in  (cd_x_r),
    .y_in  (cd_y_r),
    .done  (cd_done),
    .angle (cd_ang)
  );

  mpc_sweep #(
    .DEPTH (2 * MAX_POINTS),
    .KEY_W (KEY_W),
    .CNT_W (CNT_W)
  ) u_sweep (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (swc_r),
    .key      (key_r),
    .cnt_init (cnt0_r),
    .done     (sw_done),
    .peak     (sw_peak)
  );

  assign busy      = (st_r != T_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[rtl/mpc_isqrt.sv]
// Iterative floor square root, two radicand bits per cycle.
// Depends on mpc_pkg for the radicand and root widths.
`default_nettype none

module mpc_isqrt (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [mpc_pkg::SQ_W-1:0]  rad,
  output logic                           done,
  output logic [mpc_pkg::ROOT_W-1:0]     root
);

  localparam int W = mpc_pkg::SQ_W;

  logic [W-1:0] rem_r, rem_nxt, acc_r, acc_nxt, bit_r, bit_nxt;
  logic         run_r, run_nxt, done_r, done_nxt;
  logic [W:0]   trial;

  // One restoring step per cycle: try the next root bit against the remainder.
  always_comb begin
    trial    = {1'b0, acc_r} + {1'b0, bit_r};
    rem_nxt  = rem_r;
    acc_nxt  = acc_r;
    bit_nxt  = bit_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = rad;
      acc_nxt = '0;
      bit_nxt = W'(1) << (W - 2);
      run_nxt = 1'b1;
    end else if (run_r) begin
      if ({1'b0, rem_r} >= trial) begin
        rem_nxt = rem_r - trial[W-1:0];
        acc_nxt = (acc_r >> 1) + bit_r;
      end else begin
        acc_nxt = acc_r >> 1;
      end
      bit_nxt = bit_r >> 2;
      if (bit_r == W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    acc_r <= acc_nxt;
    bit_r <= bit_nxt;
  end

  assign done = done_r;
  assign root = acc_r[mpc_pkg::ROOT_W-1:0];

endmodule

`default_nettype wire

[rtl/mpc_cordic.sv]
// Binary angle of a vector by a 32-step vectoring CORDIC on one shared
// add/shift datapath. Depends on mpc_pkg for widths and the arctangent table.
`default_nettype none

module mpc_cordic #(
  parameter int ANGLE_BITS = 16
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             start,
  input  wire logic signed [mpc_pkg::CIN_W-1:0] x_in,
  input  wire logic signed [mpc_pkg::CIN_W-1:0] y_in,
  output logic                                  done,
  output logic [ANGLE_BITS-1:0]                 angle
);

  localparam int CW = mpc_pkg::CIN_W;
  localparam int VW = mpc_pkg::V_W;
  localparam int ZW = mpc_pkg::Z_W;
  localparam logic signed [ZW-1:0] Z_CAP = ZW'(64'd1 << 30);
  localparam logic [ANGLE_BITS-1:0] HALF = ANGLE_BITS'(1) << (ANGLE_BITS - 1);
  localparam logic [31:0] RND = 32'd1 << (31 - ANGLE_BITS);

  typedef enum logic [1:0] {C_IDLE, C_NORM, C_ITER, C_FIN} cst_t;

  cst_t                         st_r, st_nxt;
  logic signed [VW-1:0]         vx_r, vx_nxt, vy_r, vy_nxt;
  logic signed [ZW-1:0]         z_r, z_nxt;
  logic [mpc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         xneg_r, xneg_nxt, yneg_r, yneg_nxt, zero_r, zero_nxt;
  logic                         done_r, done_nxt;
  logic [ANGLE_BITS-1:0]        ang_r, ang_nxt;
  logic [CW-1:0]                ax, ay;
  logic signed [VW-1:0]         sx, sy;
  logic signed [ZW-1:0]         tab;
  logic [30:0]                  zc;
  logic [31:0]                  rsum;
  logic [ANGLE_BITS-1:0]        r;

  always_comb begin
    st_nxt   = st_r;
    vx_nxt   = vx_r;
    vy_nxt   = vy_r;
    z_nxt    = z_r;
    step_nxt = step_r;
    xneg_nxt = xneg_r;
    yneg_nxt = yneg_r;
    zero_nxt = zero_r;
    done_nxt = 1'b0;
    ang_nxt  = ang_r;
    ax   = x_in[CW-1] ? CW'(-x_in) : CW'(x_in);
    ay   = y_in[CW-1] ? CW'(-y_in) : CW'(y_in);
    sx   = vx_r >>> step_r;
    sy   = vy_r >>> step_r;
    tab  = signed'({{(ZW-32){1'b0}}, mpc_pkg::ATAN_TAB[step_r]});
    // Clamp the accumulated angle to one quarter turn, then round half up.
    if (z_r[ZW-1]) begin
      zc = '0;
    end else if (z_r > Z_CAP) begin
      zc = Z_CAP[30:0];
    end else begin
      zc = z_r[30:0];
    end
    rsum = {1'b0, zc} + RND;
    r    = rsum[31 -: ANGLE_BITS];
    case (st_r)
      C_IDLE: begin
        if (start) begin
          vx_nxt   = signed'({{(VW-CW){1'b0}}, ax});
          vy_nxt   = signed'({{(VW-CW){1'b0}}, ay});
          xneg_nxt = x_in[CW-1];
          yneg_nxt = y_in[CW-1];
          zero_nxt = (ax == '0) && (ay == '0);
          st_nxt   = ((ax == '0) && (ay == '0)) ? C_FIN : C_NORM;
        end
      end
      // Scale up one bit a cycle until a component reaches the top range.
      C_NORM: begin
        if (vx_r[VW-1:mpc_pkg::NORM_SH] == '0 && vy_r[VW-1:mpc_pkg::NORM_SH] == '0) begin
          vx_nxt = vx_r <<< 1;
          vy_nxt = vy_r <<< 1;
        end else begin
          z_nxt    = '0;
          step_nxt = '0;
          st_nxt   = C_ITER;
        end
      end
      // One micro-rotation per cycle, driving y toward zero.
      C_ITER: begin
        if (!vy_r[VW-1] && vy_r != '0) begin
          vx_nxt = vx_r + sy;
          vy_nxt = vy_r - sx;
          z_nxt  = z_r + tab;
        end else begin
          vx_nxt = vx_r - sy;
          vy_nxt = vy_r + sx;
          z_nxt  = z_r - tab;
        end
        step_nxt = step_r + 1'b1;
        if (step_r == mpc_pkg::STEP_W'(mpc_pkg::STEPS - 1)) begin
          st_nxt = C_FIN;
        end
      end
      // Map the first-quadrant angle to the quadrant of the input vector.
      C_FIN: begin
        done_nxt = 1'b1;
        st_nxt   = C_IDLE;
        if (zero_r) begin
          ang_nxt = '0;
        end else if (!xneg_r && !yneg_r) begin
          ang_nxt = r;
        end else if (xneg_r && !yneg_r) begin
          ang_nxt = HALF - r;
        end else if (xneg_r) begin
          ang_nxt = HALF + r;
        end else begin
          ang_nxt = ANGLE_BITS'(0) - r;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= C_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    vx_r   <= vx_nxt;
    vy_r   <= vy_nxt;
    z_r    <= z_nxt;
    step_r <= step_nxt;
    xneg_r <= xneg_nxt;
    yneg_r <= yneg_nxt;
    zero_r <= zero_nxt;
    ang_r  <= ang_nxt;
  end

  assign done  = done_r;
  assign angle = ang_r;

endmodule

`default_nettype wire

[rtl/mpc_sweep.sv]
// Arc-end event store with an in-place heap sort and an overlap count scan.
// Depends on mpc_pkg for the command struct.
`default_nettype none

module mpc_sweep #(
  parameter int DEPTH = 1024,
  parameter int KEY_W = 17,
  parameter int CNT_W = 11
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire mpc_pkg::sw_cmd_t        cmd,
  input  wire logic [KEY_W-1:0]        key,
  input  wire logic [CNT_W-1:0]        cnt_init,
  output logic                         done,
  output logic [CNT_W-1:0]             peak
);

  localparam int AW = $clog2(DEPTH);
  localparam int IW = AW + 1;

  typedef enum logic [3:0] {
    W_IDLE, W_HNEXT, W_HLD, W_SRD, W_SCMP, W_ERD, W_ESWAP, W_CRD, W_CUPD
  } wst_t;

  logic [KEY_W-1:0] mem [DEPTH];

  wst_t             st_r, st_nxt;
  logic [IW-1:0]    m_r, m_nxt, n_r, n_nxt, hi_r, hi_nxt, e_r, e_nxt;
  logic [IW-1:0]    node_r, node_nxt, heapn_r, heapn_nxt, child_r, child_nxt, k_r, k_nxt;
  logic [KEY_W-1:0] v_r, v_nxt, rd0_r, rd1_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, peak_r, peak_nxt;
  logic             sorting_r, sorting_nxt, done_r, done_nxt;
  logic             we;
  logic [AW-1:0]    waddr, raddr0, raddr1;
  logic [KEY_W-1:0] wdata, cval;
  logic [IW-1:0]    lft, hi_dec, cidx;
  logic             pick;
  logic [CNT_W-1:0] cnew;
  wst_t             ret_st;

  always_comb begin
    st_nxt      = st_r;
    m_nxt       = m_r;
    n_nxt       = n_r;
    hi_nxt      = hi_r;
    e_nxt       = e_r;
    node_nxt    = node_r;
    heapn_nxt   = heapn_r;
    child_nxt   = child_r;
    k_nxt       = k_r;
    v_nxt       = v_r;
    cnt_nxt     = cnt_r;
    peak_nxt    = peak_r;
    sorting_nxt = sorting_r;
    done_nxt    = 1'b0;
    we          = 1'b0;
    waddr       = node_r[AW-1:0];
    wdata       = v_r;
    raddr0      = '0;
    raddr1      = '0;
    lft         = IW'({node_r, 1'b1});
    hi_dec      = hi_r - 1'b1;
    pick        = ((child_r + 1'b1) < heapn_r) && (rd1_r > rd0_r);
    cval        = pick ? rd1_r : rd0_r;
    cidx        = pick ? child_r + 1'b1 : child_r;
    cnew        = rd0_r[0] ? cnt_r + 1'b1 : cnt_r - 1'b1;
    ret_st      = sorting_r ? W_ERD : W_HNEXT;
    case (st_r)
      // Collect events; a go beat starts the sort.
      W_IDLE: begin
        if (cmd.clr) begin
          m_nxt = '0;
        end
        if (cmd.push) begin
          we    = 1'b1;
          waddr = m_r[AW-1:0];
          wdata = key;
          m_nxt = m_r + 1'b1;
        end
        if (cmd.go) begin
          n_nxt       = m_r;
          cnt_nxt     = cnt_init;
          peak_nxt    = cnt_init;
          k_nxt       = '0;
          hi_nxt      = m_r >> 1;
          sorting_nxt = 1'b0;
          st_nxt      = (m_r < IW'(2)) ? W_CRD : W_HNEXT;
        end
      end
      // Heap build: sift down every inner node, last one first.
      W_HNEXT: begin
        if (hi_r == '0) begin
          e_nxt       = n_r - 1'b1;
          sorting_nxt = 1'b1;
          st_nxt      = W_ERD;
        end else begin
          node_nxt  = hi_dec;
          hi_nxt    = hi_dec;
          heapn_nxt = n_r;
          raddr0    = hi_dec[AW-1:0];
          st_nxt    = W_HLD;
        end
      end
      W_HLD: begin
        v_nxt  = rd0_r;
        st_nxt = W_SRD;
      end
      // Sift step: fetch both children of the hole, or settle the value.
      W_SRD: begin
        if (lft >= heapn_r) begin
          we     = 1'b1;
          st_nxt = ret_st;
        end else begin
          raddr0    = lft[AW-1:0];
          raddr1    = AW'(lft + 1'b1);
          child_nxt = lft;
          st_nxt    = W_SCMP;
        end
      end
      W_SCMP: begin
        we = 1'b1;
        if (cval <= v_r) begin
          st_nxt = ret_st;
        end else begin
          wdata    = cval;
          node_nxt = cidx;
          st_nxt   = W_SRD;
        end
      end
      // Extraction: move the root to the end and sift the old end value down.
      W_ERD: begin
        if (e_r == '0) begin
          k_nxt  = '0;
          st_nxt = W_CRD;
        end else begin
          raddr0 = '0;
          raddr1 = e_r[AW-1:0];
          st_nxt = W_ESWAP;
        end
      end
      W_ESWAP: begin
        we        = 1'b1;
        waddr     = e_r[AW-1:0];
        wdata     = rd0_r;
        v_nxt     = rd1_r;
        node_nxt  = '0;
        heapn_nxt = e_r;
        e_nxt     = e_r - 1'b1;
        st_nxt    = W_SRD;
      end
      // Scan in angle order: entries raise the count, exits lower it.
      W_CRD: begin
        if (k_r == n_r) begin
          done_nxt = 1'b1;
          st_nxt   = W_IDLE;
        end else begin
          raddr0 = k_r[AW-1:0];
          k_nxt  = k_r + 1'b1;
          st_nxt = W_CUPD;
        end
      end
      W_CUPD: begin
        cnt_nxt = cnew;
        if (cnew > peak_r) begin
          peak_nxt = cnew;
        end
        st_nxt = W_CRD;
      end
      default: st_nxt = W_IDLE;
    endcase
  end

  // Event memory: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_r <= mem[raddr0];
    rd1_r <= mem[raddr1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= W_IDLE;
      m_r    <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      m_r    <= m_nxt;
      done_r <= done_nxt;
    end
    n_r       <= n_nxt;
    hi_r      <= hi_nxt;
    e_r       <= e_nxt;
    node_r    <= node_nxt;
    heapn_r   <= heapn_nxt;
    child_r   <= child_nxt;
    k_r       <= k_nxt;
    v_r       <= v_nxt;
    cnt_r     <= cnt_nxt;
    peak_r    <= peak_nxt;
    sorting_r <= sorting_nxt;
  end

  assign done = done_r;
  assign peak = peak_r;

endmodule

`default_nettype wire

[rtl/mpc_checker.sv]
// Port-level checks for the max-points-in-unit-circle block, bound to the top.
// Depends on mpc_pkg for the beat types.
`default_nettype none

module mpc_port_checks (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire mpc_pkg::in_beat_t  in_data,
  input wire logic               out_valid,
  input wire mpc_pkg::out_beat_t out_data
);

  // A result beat lasts one cycle.
  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat held longer than one cycle");

  // The closing point starts the sweep.
  a_last_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_data.last_point) |=> busy)
    else $error("closing point did not start the sweep");

  // The block only goes idle by delivering a result.
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_valid)
    else $error("sweep ended without a result beat");

  // A result always covers at least its own center point.
  a_result_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.max_covered != '0 && !busy))
    else $error("result beat with zero count or while busy");

endmodule

bind max_points_in_unit_circle mpc_port_checks u_mpc_port_checks (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);

`default_nettype wire
